[rtl/spq_pkg.sv]
package spq_pkg;

    // Operation codes carried in the kind field of a request beat.
    typedef enum logic [2:0] {
        KIND_OFFER           = 3'd0,
        KIND_POLL            = 3'd1,
        KIND_READ_AT         = 3'd2,
        KIND_REMOVE_AT       = 3'd3,
        KIND_REMOVE_MATCHING = 3'd4
    } kind_t;

    // Status codes reported with every response beat.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // What every cell of the row does in the current cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE_AT,
        CELL_DELETE_MATCH
    } cell_op_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_PURGE
    } state_t;

    // Control word broadcast to all cells.
    typedef struct packed {
        cell_op_t op;
        logic     use_sec;
    } cell_ctrl_t;

endpackage

[rtl/spq_req_if.sv]
interface spq_req_if #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16,
    parameter int POS_BITS = 4
);
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [KEY_BITS-1:0] primary_key;
    logic [KEY_BITS-1:0] secondary_key;
    logic [TAG_BITS-1:0] entry_tag;
    logic [POS_BITS-1:0] position;

    modport source (
        output valid, kind, primary_key, secondary_key, entry_tag, position,
        input  ready
    );

    modport sink (
        input  valid, kind, primary_key, secondary_key, entry_tag, position,
        output ready
    );
endinterface

[rtl/spq_rsp_if.sv]
interface spq_rsp_if #(
    parameter int TAG_BITS = 16,
    parameter int CNT_BITS = 5
);
    logic                valid;
    logic                ready;
    logic [TAG_BITS-1:0] result_tag;
    logic                result_valid;
    logic [1:0]          status;
    logic [CNT_BITS-1:0] removed_count;
    logic [CNT_BITS-1:0] occupancy;
    logic [TAG_BITS-1:0] head_tag;
    logic                head_valid;

    modport source (
        output valid, result_tag, result_valid, status, removed_count,
               occupancy, head_tag, head_valid,
        input  ready
    );

    modport sink (
        input  valid, result_tag, result_valid, status, removed_count,
               occupancy, head_tag, head_valid,
        output ready
    );
endinterface

[rtl/spq_cfg_if.sv]
interface spq_cfg_if;
    logic valid;
    logic ready;
    logic use_secondary_key;

    modport source (
        output valid, use_secondary_key,
        input  ready
    );

    modport sink (
        input  valid, use_secondary_key,
        output ready
    );
endinterface

[rtl/spq_cell.sv]
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16,
    parameter int POS_BITS = 4,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic [KEY_BITS-1:0] new_pk,
    input  logic [KEY_BITS-1:0] new_sk,
    input  logic [TAG_BITS-1:0] new_tag,
    input  logic [POS_BITS-1:0] pos,
    input  logic [TAG_BITS-1:0] target_tag,
    // Neighbour towards the head.
    input  logic                left_valid,
    input  logic [KEY_BITS-1:0] left_pk,
    input  logic [KEY_BITS-1:0] left_sk,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic                left_ge,
    input  logic                left_del,
    // Neighbour towards the tail.
    input  logic                right_valid,
    input  logic [KEY_BITS-1:0] right_pk,
    input  logic [KEY_BITS-1:0] right_sk,
    input  logic [TAG_BITS-1:0] right_tag,
    // Own contents and chain outputs.
    output logic                valid,
    output logic [KEY_BITS-1:0] pk,
    output logic [KEY_BITS-1:0] sk,
    output logic [TAG_BITS-1:0] tag,
    output logic                ge,
    output logic                del,
    output logic                next_valid,
    output logic [TAG_BITS-1:0] next_tag
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] pk_reg, pk_next;
    logic [KEY_BITS-1:0] sk_reg, sk_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                greater;
    logic                hit;

    // The stored entry sorts after the offered one, the cell is free, or a
    // cell nearer the head has already made room for the offered entry.
    always_comb
    begin
        greater = (pk_reg > new_pk) ||
                  (ctrl.use_sec && (pk_reg == new_pk) && (sk_reg > new_sk));
        ge      = left_ge || !valid_reg || greater;
    end

    // This cell is the one to delete; everything behind it moves up.
    always_comb
    begin
        case (ctrl.op)
            CELL_DELETE_AT:    hit = (pos == POS_BITS'(INDEX));
            CELL_DELETE_MATCH: hit = valid_reg && (tag_reg == target_tag);
            default:           hit = 1'b0;
        endcase
        del = left_del || hit;
    end

    // Next contents: take from the left on insert, from the right on delete.
    always_comb
    begin
        valid_next = valid_reg;
        pk_next    = pk_reg;
        sk_next    = sk_reg;
        tag_next   = tag_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (left_ge)
                begin
                    valid_next = left_valid;
                    pk_next    = left_pk;
                    sk_next    = left_sk;
                    tag_next   = left_tag;
                end
                else if (ge)
                begin
                    valid_next = 1'b1;
                    pk_next    = new_pk;
                    sk_next    = new_sk;
                    tag_next   = new_tag;
                end
            end
            CELL_DELETE_AT, CELL_DELETE_MATCH:
            begin
                if (del)
                begin
                    valid_next = right_valid;
                    pk_next    = right_pk;
                    sk_next    = right_sk;
                    tag_next   = right_tag;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pk_reg  <= pk_next;
        sk_reg  <= sk_next;
        tag_reg <= tag_next;
    end

    assign valid      = valid_reg;
    assign pk         = pk_reg;
    assign sk         = sk_reg;
    assign tag        = tag_reg;
    assign next_valid = valid_next;
    assign next_tag   = tag_next;

endmodule

[rtl/spq_row.sv]
module spq_row
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16,
    parameter int POS_BITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic [KEY_BITS-1:0] new_pk,
    input  logic [KEY_BITS-1:0] new_sk,
    input  logic [TAG_BITS-1:0] new_tag,
    input  logic [POS_BITS-1:0] pos,
    input  logic [TAG_BITS-1:0] target_tag,
    output logic [TAG_BITS-1:0] read_tag,
    output logic                head_next_valid,
    output logic [TAG_BITS-1:0] head_next_tag,
    output logic                found
);

    logic                valid_w    [CAPACITY];
    logic [KEY_BITS-1:0] pk_w       [CAPACITY];
    logic [KEY_BITS-1:0] sk_w       [CAPACITY];
    logic [TAG_BITS-1:0] tag_w      [CAPACITY];
    logic                ge_w       [CAPACITY];
    logic                del_w      [CAPACITY];
    logic                nvalid_w   [CAPACITY];
    logic [TAG_BITS-1:0] ntag_w     [CAPACITY];

    // The row of cells, slot 0 at the head.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                l_valid, l_ge, l_del, r_valid;
        logic [KEY_BITS-1:0] l_pk, l_sk, r_pk, r_sk;
        logic [TAG_BITS-1:0] l_tag, r_tag;

        if (i == 0)
        begin : g_first
            assign l_valid = 1'b0;
            assign l_pk    = '0;
            assign l_sk    = '0;
            assign l_tag   = '0;
            assign l_ge    = 1'b0;
            assign l_del   = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_valid = valid_w[i-1];
            assign l_pk    = pk_w[i-1];
            assign l_sk    = sk_w[i-1];
            assign l_tag   = tag_w[i-1];
            assign l_ge    = ge_w[i-1];
            assign l_del   = del_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_pk    = '0;
            assign r_sk    = '0;
            assign r_tag   = '0;
        end
        else
        begin : g_mid_r
            assign r_valid = valid_w[i+1];
            assign r_pk    = pk_w[i+1];
            assign r_sk    = sk_w[i+1];
            assign r_tag   = tag_w[i+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS),
            .POS_BITS (POS_BITS),
            .INDEX    (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_pk      (new_pk),
            .new_sk      (new_sk),
            .new_tag     (new_tag),
            .pos         (pos),
            .target_tag  (target_tag),
            .left_valid  (l_valid),
            .left_pk     (l_pk),
            .left_sk     (l_sk),
            .left_tag    (l_tag),
            .left_ge     (l_ge),
            .left_del    (l_del),
            .right_valid (r_valid),
            .right_pk    (r_pk),
            .right_sk    (r_sk),
            .right_tag   (r_tag),
            .valid       (valid_w[i]),
            .pk          (pk_w[i]),
            .sk          (sk_w[i]),
            .tag         (tag_w[i]),
            .ge          (ge_w[i]),
            .del         (del_w[i]),
            .next_valid  (nvalid_w[i]),
            .next_tag    (ntag_w[i])
        );
    end

    // Tag of the slot at the requested position.
    always_comb
    begin
        read_tag = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pos == POS_BITS'(i))
            begin
                read_tag = tag_w[i];
            end
        end
    end

    // Head after this cycle, and whether a delete found its slot.
    assign head_next_valid = nvalid_w[0];
    assign head_next_tag   = ntag_w[0];
    assign found           = del_w[CAPACITY-1];

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue built as a row of shift cells, head in slot 0.
//
// Channels: req carries one operation per beat (offer, poll, read_at,
// remove_at, remove_matching); rsp returns exactly one beat per operation,
// always reporting the head tag and the occupancy after the operation;
// cfg writes use_secondary_key, which must only change while the queue is
// idle. cfg is always ready.
// The response to offer, poll, read_at, remove_at or an unknown kind is
// registered in the cycle after its request beat; while rsp is not stalled
// a new request can be taken in every cycle, so these run at one item per
// cycle. remove_matching deletes one matching entry per cycle through the
// row and answers once no match is left; req is not ready meanwhile.
// Reset empties the queue (all cell valid bits clear) and clears the
// configuration; cell contents are not reset.
// Stalls: the response sits in an output register; while rsp is stalled
// with a beat waiting, req is held not ready and the queue keeps its state.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp,
    spq_cfg_if.sink   cfg
);

    localparam int POS_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] purge_reg, purge_next;
    logic [TAG_BITS-1:0] target_reg, target_next;
    logic                use_sec_reg;

    logic                out_valid_reg, out_valid_next;
    logic [TAG_BITS-1:0] out_rtag_reg, out_rtag_next;
    logic                out_rvalid_reg, out_rvalid_next;
    status_t             out_status_reg, out_status_next;
    logic [CNT_BITS-1:0] out_removed_reg, out_removed_next;
    logic [CNT_BITS-1:0] out_occ_reg, out_occ_next;
    logic [TAG_BITS-1:0] out_htag_reg, out_htag_next;
    logic                out_hvalid_reg, out_hvalid_next;

    logic                accept;
    logic                load;
    logic                in_range;
    cell_ctrl_t          ctrl;
    logic [POS_BITS-1:0] cell_pos;
    logic [TAG_BITS-1:0] read_tag;
    logic                head_next_valid;
    logic [TAG_BITS-1:0] head_next_tag;
    logic                found;

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Poll always works on the head slot.
    assign cell_pos = (req.kind == KIND_POLL) ? '0 : req.position;
    assign in_range = CNT_BITS'(cell_pos) < count_reg;

    spq_row #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS),
        .POS_BITS (POS_BITS)
    ) u_row (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .new_pk          (req.primary_key),
        .new_sk          (req.secondary_key),
        .new_tag         (req.entry_tag),
        .pos             (cell_pos),
        .target_tag      (target_reg),
        .read_tag        (read_tag),
        .head_next_valid (head_next_valid),
        .head_next_tag   (head_next_tag),
        .found           (found)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.kind == KIND_REMOVE_MATCHING))
                begin
                    state_next = ST_PURGE;
                end
            end
            ST_PURGE:
            begin
                if (!found)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cell control, counters and the response fields.
    always_comb
    begin
        ctrl.op         = CELL_HOLD;
        ctrl.use_sec    = use_sec_reg;
        count_next      = count_reg;
        purge_next      = purge_reg;
        target_next     = target_reg;
        load            = 1'b0;
        out_rtag_next   = '0;
        out_rvalid_next = 1'b0;
        out_status_next = STATUS_OK;
        out_removed_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (req.kind)
                        KIND_OFFER:
                        begin
                            if (count_reg == CNT_BITS'(CAPACITY))
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_POLL, KIND_READ_AT, KIND_REMOVE_AT:
                        begin
                            if (!in_range)
                            begin
                                out_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                out_rtag_next   = read_tag;
                                out_rvalid_next = 1'b1;
                                if (req.kind != KIND_READ_AT)
                                begin
                                    ctrl.op    = CELL_DELETE_AT;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        KIND_REMOVE_MATCHING:
                        begin
                            load        = 1'b0;
                            purge_next  = '0;
                            target_next = req.entry_tag;
                        end
                        default:
                        begin
                            out_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_PURGE:
            begin
                // One matching entry leaves the row per cycle.
                ctrl.op = CELL_DELETE_MATCH;
                if (found)
                begin
                    count_next = count_reg - 1'b1;
                    purge_next = purge_reg + 1'b1;
                end
                else
                begin
                    load             = 1'b1;
                    out_removed_next = purge_reg;
                end
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase

        out_occ_next    = count_next;
        out_hvalid_next = head_next_valid;
        out_htag_next   = head_next_valid ? head_next_tag : '0;
        out_valid_next  = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            use_sec_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                use_sec_reg <= cfg.use_secondary_key;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        purge_reg  <= purge_next;
        target_reg <= target_next;
        if (load)
        begin
            out_rtag_reg    <= out_rtag_next;
            out_rvalid_reg  <= out_rvalid_next;
            out_status_reg  <= out_status_next;
            out_removed_reg <= out_removed_next;
            out_occ_reg     <= out_occ_next;
            out_htag_reg    <= out_htag_next;
            out_hvalid_reg  <= out_hvalid_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_tag    = out_rtag_reg;
    assign rsp.result_valid  = out_rvalid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_count = out_removed_reg;
    assign rsp.occupancy     = out_occ_reg;
    assign rsp.head_tag      = out_htag_reg;
    assign rsp.head_valid    = out_hvalid_reg;

endmodule
